// ===== rtl/hng_pkg.sv =====
// shared types and constants for the heightmap normal generator
// no dependencies; used by every module of the block
`default_nettype none

package hng_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int SAMPLE_W  = 16;
  localparam int COORD_W   = 12;
  localparam int ROW_W     = 13;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PEAK   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic [15:0]      PEAK_RESET = 16'd65535;
  localparam logic [12:0]      SIZE_RESET = 13'd3601;
  localparam logic [ROW_W-1:0] MAX_ROWS   = 13'd4096;
  localparam logic [15:0]      HEIGHT_ONE = 16'd65280;
  localparam logic [14:0]      Q14_ONE    = 15'd16384;

  // controller to datapath
  typedef struct packed {
    logic                cap_sample;
    logic                cap_mid;
    logic                cap_right;
    logic                cap_left;
    logic                zero_top;
    logic                zero_right;
    logic                zero_left;
    logic                flush;
    logic                wr_en;
    logic                clr_left;
    logic                start;
    logic                load_out;
    logic [15:0]         peak;
    logic [COORD_W-1:0]  col;
    logic [COORD_W-1:0]  row;
    logic                last;
  } hng_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic norm_done;
    logic out_full;
  } hng_stat_t;

endpackage

`default_nettype wire

// ===== rtl/hng_norm.sv =====
// iterative unit: scaled height by restoring division, and the unit normal
// by squared length, long division and bitwise square root; uses hng_pkg
`default_nettype none

module hng_norm
  import hng_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [15:0]       ctr,
  input  wire logic [15:0]       left,
  input  wire logic [15:0]       right,
  input  wire logic [15:0]       top,
  input  wire logic [15:0]       bottom,
  input  wire logic [15:0]       peak,
  output logic                   done,
  output logic [15:0]            sh,
  output logic signed [15:0]     nx,
  output logic signed [14:0]     ny,
  output logic signed [15:0]     nz
);

  localparam logic [2:0] N_IDLE  = 3'd0;
  localparam logic [2:0] N_SQ    = 3'd1;
  localparam logic [2:0] N_SUM   = 3'd2;
  localparam logic [2:0] N_INIT  = 3'd3;
  localparam logic [2:0] N_DIV   = 3'd4;
  localparam logic [2:0] N_ROOT  = 3'd5;
  localparam logic [2:0] N_STORE = 3'd6;
  localparam logic [2:0] N_DONE  = 3'd7;

  logic [2:0]  state;
  logic [1:0]  k;
  logic [4:0]  cnt;
  logic [4:0]  hcnt;

  logic [23:0] ax, az;
  logic [16:0] ay;
  logic        sx, sz;
  logic [15:0] pe;
  logic        sat;
  logic [47:0] sq [3];
  logic [49:0] s;
  logic [49:0] rem;
  logic [30:0] q;
  logic [31:0] sd;
  logic [17:0] srem;
  logic [15:0] sres;
  logic [14:0] n [3];
  logic [15:0] hrem;
  logic [15:0] hlo;
  logic [15:0] hq;

  // start values
  logic signed [16:0] dx, dz;
  logic [15:0]        mx, mz;
  logic [15:0]        pe_in;
  logic [31:0]        hnum;

  always_comb begin
    dx    = $signed({1'b0, right}) - $signed({1'b0, left});
    dz    = $signed({1'b0, bottom}) - $signed({1'b0, top});
    mx    = dx[16] ? 16'(-dx) : dx[15:0];
    mz    = dz[16] ? 16'(-dz) : dz[15:0];
    pe_in = (peak == 16'd0) ? 16'd1 : peak;
    hnum  = {ctr, 16'd0} - {8'd0, ctr, 8'd0} + {17'd0, pe_in[15:1]};
  end

  // shared squarer
  logic [23:0] sq_op;
  logic [47:0] sq_k;
  always_comb begin
    unique case (k)
      2'd0:    sq_op = ax;
      2'd1:    sq_op = {7'd0, ay};
      default: sq_op = az;
    endcase
    unique case (k)
      2'd0:    sq_k = sq[0];
      2'd1:    sq_k = sq[1];
      default: sq_k = sq[2];
    endcase
  end

  // one long-division step
  logic        bit_in;
  logic [50:0] dt;
  logic        dge;
  logic [30:0] q_next;
  always_comb begin
    bit_in = (cnt == 5'd0) ? sq_k[0] : 1'b0;
    dt     = {rem, bit_in};
    dge    = dt >= {1'b0, s};
    q_next = {q[29:0], dge};
  end

  // one square-root step
  logic [19:0] rr, tr;
  logic        rge;
  always_comb begin
    rr  = {srem, sd[31:30]};
    tr  = {2'd0, sres, 2'b01};
    rge = rr >= tr;
  end

  // halving of the root, rounded to nearest
  logic [16:0] nh;
  assign nh = ({1'b0, sres} + 17'd1) >> 1;

  // height division step
  logic [16:0] ht;
  logic        hge;
  always_comb begin
    ht  = {hrem, hlo[15]};
    hge = ht >= {1'b0, pe};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      k     <= 2'd0;
      cnt   <= 5'd0;
      hcnt  <= 5'd0;
    end else begin
      if (hcnt != 5'd0) begin
        hrem <= hge ? 16'(ht - {1'b0, pe}) : ht[15:0];
        hlo  <= {hlo[14:0], 1'b0};
        hq   <= {hq[14:0], hge};
        hcnt <= hcnt - 5'd1;
      end
      unique case (state)
        N_IDLE: begin
          if (start) begin
            ax    <= {mx, 8'd0} - {8'd0, mx};
            az    <= {mz, 8'd0} - {8'd0, mz};
            ay    <= {pe_in, 1'b0};
            sx    <= dx[16];
            sz    <= dz[16];
            pe    <= pe_in;
            sat   <= ctr >= pe_in;
            hrem  <= hnum[31:16];
            hlo   <= hnum[15:0];
            hq    <= 16'd0;
            hcnt  <= 5'd16;
            k     <= 2'd0;
            state <= N_SQ;
          end
        end
        N_SQ: begin
          sq[k] <= sq_op * sq_op;
          if (k == 2'd2) begin
            state <= N_SUM;
          end else begin
            k <= k + 2'd1;
          end
        end
        N_SUM: begin
          s     <= {2'd0, sq[0]} + {2'd0, sq[1]} + {2'd0, sq[2]};
          k     <= 2'd0;
          state <= N_INIT;
        end
        N_INIT: begin
          rem   <= {3'd0, sq_k[47:1]};
          q     <= 31'd0;
          cnt   <= 5'd0;
          state <= N_DIV;
        end
        N_DIV: begin
          rem <= dge ? 50'(dt - {1'b0, s}) : dt[49:0];
          q   <= q_next;
          if (cnt == 5'd30) begin
            sd    <= {1'b0, q_next};
            srem  <= 18'd0;
            sres  <= 16'd0;
            cnt   <= 5'd0;
            state <= N_ROOT;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        N_ROOT: begin
          srem <= rge ? 18'(rr - tr) : rr[17:0];
          sres <= {sres[14:0], rge};
          sd   <= {sd[29:0], 2'b00};
          if (cnt == 5'd15) begin
            state <= N_STORE;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        N_STORE: begin
          n[k] <= (nh > {2'd0, Q14_ONE}) ? Q14_ONE : nh[14:0];
          if (k == 2'd2) begin
            state <= N_DONE;
          end else begin
            k     <= k + 2'd1;
            state <= N_INIT;
          end
        end
        default: begin
          state <= N_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    done = state == N_DONE;
    sh   = sat ? HEIGHT_ONE : hq;
    nx   = sx ? -$signed({1'b0, n[0]}) : $signed({1'b0, n[0]});
    ny   = -$signed(n[1]);
    nz   = sz ? -$signed({1'b0, n[2]}) : $signed({1'b0, n[2]});
  end

endmodule

`default_nettype wire

// ===== rtl/hng_dp.sv =====
// datapath: the two line stores, neighbour registers, the normal unit and
// the output register; depends on hng_pkg and hng_norm
`default_nettype none

module hng_dp
  import hng_pkg::*;
#(
  parameter int MAX_LINE = 4096
)
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire hng_cmd_t                     cmd,
  input  wire logic [$clog2(MAX_LINE)-1:0]  addr,
  input  wire logic [7:0]                   high_byte,
  input  wire logic [7:0]                   low_byte,
  output hng_stat_t                         stat,
  input  wire logic                         result_stall,
  output logic                              result_valid,
  output logic [COORD_W-1:0]                column,
  output logic [COORD_W-1:0]                row,
  output logic [15:0]                       scaled_height,
  output logic signed [15:0]                normal_x,
  output logic signed [14:0]                normal_y,
  output logic signed [15:0]                normal_z,
  output logic                              last_in_frame
);

  logic [SAMPLE_W-1:0] mid_mem [MAX_LINE];
  logic [SAMPLE_W-1:0] up_mem  [MAX_LINE];
  logic [SAMPLE_W-1:0] mid_q, up_q;

  logic [15:0] sample, ctr, top, right, left, bottom, left_above;

  always_ff @(posedge clk) begin
    mid_q <= mid_mem[addr];
    up_q  <= up_mem[addr];
    if (cmd.wr_en) begin
      mid_mem[addr] <= sample;
      up_mem[addr]  <= ctr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_sample) begin
      sample <= {high_byte, low_byte};
    end
    if (cmd.cap_mid) begin
      ctr <= mid_q;
      top <= cmd.zero_top ? 16'd0 : up_q;
    end
    if (cmd.cap_right) begin
      right <= cmd.zero_right ? 16'd0 : mid_q;
    end
    if (cmd.cap_left) begin
      priority if (cmd.zero_left) begin
        left <= 16'd0;
      end else if (cmd.flush) begin
        left <= mid_q;
      end else begin
        left <= left_above;
      end
      bottom <= cmd.flush ? 16'd0 : sample;
    end
  end

  // row-above value of the previous column
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_left) begin
      left_above <= 16'd0;
    end else if (cmd.wr_en) begin
      left_above <= ctr;
    end
  end

  logic               n_done;
  logic [15:0]        n_sh;
  logic signed [15:0] n_x, n_z;
  logic signed [14:0] n_y;

  hng_norm u_norm (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.start),
    .ctr    (ctr),
    .left   (left),
    .right  (right),
    .top    (top),
    .bottom (bottom),
    .peak   (cmd.peak),
    .done   (n_done),
    .sh     (n_sh),
    .nx     (n_x),
    .ny     (n_y),
    .nz     (n_z)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      column        <= cmd.col;
      row           <= cmd.row;
      scaled_height <= n_sh;
      normal_x      <= n_x;
      normal_y      <= n_y;
      normal_z      <= n_z;
      last_in_frame <= cmd.last;
    end
  end

  always_comb begin
    stat.norm_done = n_done;
    stat.out_full  = result_valid && result_stall;
  end

endmodule

`default_nettype wire

// ===== rtl/hng_ctrl.sv =====
// controller: configuration registers, raster and flush counters and the
// sequence of line store reads, write-back and normalising; uses hng_pkg
`default_nettype none

module hng_ctrl
  import hng_pkg::*;
#(
  parameter int MAX_LINE = 4096
)
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [15:0]                  cfg_data,
  input  wire logic                         item_valid,
  output logic                              item_stall,
  input  wire logic                         action,
  input  wire hng_stat_t                    stat,
  output hng_cmd_t                          cmd,
  output logic [$clog2(MAX_LINE)-1:0]       addr
);

  localparam int AW    = $clog2(MAX_LINE);
  localparam int LW    = $clog2(MAX_LINE + 1);
  localparam int CMP_W = (LW > 13) ? LW : 13;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDC  = 3'd1;
  localparam logic [2:0] S_RDR  = 3'd2;
  localparam logic [2:0] S_RDL  = 3'd3;
  localparam logic [2:0] S_CAPL = 3'd4;
  localparam logic [2:0] S_GO   = 3'd5;
  localparam logic [2:0] S_NORM = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]       state;
  logic [15:0]      peak_height;
  logic [12:0]      tile_width, tile_height;
  logic [AW-1:0]    input_column, flush_column, cur_col;
  logic [ROW_W-1:0] input_row, cur_row;
  logic             is_flush, emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_height <= PEAK_RESET;
      tile_width  <= SIZE_RESET;
      tile_height <= SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PEAK:   peak_height <= cfg_data;
        REG_WIDTH:  tile_width  <= cfg_data[12:0];
        REG_HEIGHT: tile_height <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // clamped sizes
  logic [LW-1:0]    w_eff;
  logic [ROW_W-1:0] h_eff;
  logic [CMP_W-1:0] tw_x;
  always_comb begin
    tw_x = CMP_W'(tile_width);
    priority if (tile_width == 13'd0) begin
      w_eff = LW'(1);
    end else if (tw_x > CMP_W'(MAX_LINE)) begin
      w_eff = LW'(MAX_LINE);
    end else begin
      w_eff = tw_x[LW-1:0];
    end
    priority if (tile_height == 13'd0) begin
      h_eff = 13'd1;
    end else if (tile_height > MAX_ROWS) begin
      h_eff = MAX_ROWS;
    end else begin
      h_eff = tile_height;
    end
  end

  logic             accept;
  logic             wrap;
  logic [ROW_W-1:0] row_start;
  logic [LW-1:0]    fc_x;
  logic [LW-1:0]    col_inc;
  logic             right_ok;
  always_comb begin
    accept    = item_valid && !item_stall;
    wrap      = LW'(input_column) >= w_eff;
    row_start = wrap ? input_row + 13'd1 : input_row;
    fc_x      = (LW'(flush_column) >= w_eff) ? w_eff - LW'(1) : LW'(flush_column);
    col_inc   = LW'(cur_col) + LW'(1);
    right_ok  = col_inc < w_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      input_column <= '0;
      input_row    <= '0;
      flush_column <= '0;
      cur_col      <= '0;
      cur_row      <= '0;
      is_flush     <= 1'b0;
      emit         <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && !action && input_row < h_eff) begin
            if (wrap) begin
              input_column <= '0;
              input_row    <= row_start;
            end
            if (row_start < h_eff) begin
              cur_col  <= wrap ? '0 : input_column;
              cur_row  <= row_start;
              is_flush <= 1'b0;
              emit     <= row_start != 13'd0;
              state    <= S_RDC;
            end
          end else if (accept && action && input_row >= h_eff) begin
            cur_col  <= fc_x[AW-1:0];
            is_flush <= 1'b1;
            emit     <= 1'b1;
            state    <= S_RDC;
          end
        end
        S_RDC: state <= S_RDR;
        S_RDR: state <= S_RDL;
        S_RDL: state <= S_CAPL;
        S_CAPL: begin
          if (is_flush) begin
            if (cmd.last) begin
              input_column <= '0;
              input_row    <= '0;
              flush_column <= '0;
            end else begin
              flush_column <= col_inc[AW-1:0];
            end
          end else if (!right_ok) begin
            input_column <= '0;
            input_row    <= cur_row + 13'd1;
          end else begin
            input_column <= col_inc[AW-1:0];
            input_row    <= cur_row;
          end
          state <= emit ? S_GO : S_IDLE;
        end
        S_GO: state <= S_NORM;
        S_NORM: begin
          if (stat.norm_done) begin
            state <= S_OUT;
          end
        end
        default: begin
          if (!stat.out_full) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  always_comb begin
    // a pending register write goes first, so no word is in flight across it
    item_stall = (state != S_IDLE) || cfg_valid;
    cfg_ready  = state == S_IDLE;

    unique case (state)
      S_RDR:   addr = col_inc[AW-1:0];
      S_RDL:   addr = cur_col - AW'(1);
      default: addr = cur_col;
    endcase

    cmd.cap_sample = accept && !action;
    cmd.cap_mid    = state == S_RDR;
    cmd.cap_right  = state == S_RDL;
    cmd.cap_left   = state == S_CAPL;
    cmd.zero_top   = is_flush ? (h_eff < 13'd2) : (cur_row == 13'd1);
    cmd.zero_right = !right_ok;
    cmd.zero_left  = cur_col == '0;
    cmd.flush      = is_flush;
    cmd.wr_en      = (state == S_CAPL) && !is_flush;
    cmd.clr_left   = (state == S_CAPL) && is_flush && cmd.last;
    cmd.start      = state == S_GO;
    cmd.load_out   = (state == S_OUT) && !stat.out_full;
    cmd.peak       = peak_height;
    cmd.col        = COORD_W'(cur_col);
    cmd.row        = is_flush ? COORD_W'(h_eff - 13'd1) : COORD_W'(cur_row - 13'd1);
    cmd.last       = is_flush && (col_inc == w_eff);
  end

endmodule

`default_nettype wire

// ===== rtl/heightmap_normal_generator.sv =====
// heightmap normal generator, top level
// depends on hng_pkg, hng_ctrl, hng_dp (which holds hng_norm)
//
// usage:
//   configure peak_height, tile_width and tile_height over the cfg port
//   (index 0, 1, 2) while the block is idle; cfg_ready is high when idle,
//   and a pending cfg write holds off the item channel for that cycle.
//   item channel: action 0 carries a big-endian elevation word in raster
//   order, action 1 flushes one pixel of the last row once all rows are in.
//   each sample word from the second row on gives the pixel one row above;
//   first-row words and words out of turn give nothing.
//   result channel: column, row, scaled height (Q8.8) and unit normal (Q1.14).
// timing:
//   one word at a time; a word that gives a pixel reaches the result
//   register after the line store reads, the write-back and the shared
//   divide and square-root loop, run once per normal component (31 + 16
//   steps each); the next word is taken once the result is loaded. a
//   word that gives no pixel does not start the normal unit.
//   the next word is taken while a result waits in the output register; a
//   stalled result holds and only the next result waits behind it.
// reset: counters go to the start of a tile, registers to their reset
//   values; line stores are not cleared and hold data only once written.
`default_nettype none

module heightmap_normal_generator
  import hng_pkg::*;
#(
  parameter int MAX_LINE = 4096
)
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [15:0]           cfg_data,
  input  wire logic                  item_valid,
  output logic                       item_stall,
  input  wire logic                  action,
  input  wire logic [7:0]            high_byte,
  input  wire logic [7:0]            low_byte,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output logic [COORD_W-1:0]         column,
  output logic [COORD_W-1:0]         row,
  output logic [15:0]                scaled_height,
  output logic signed [15:0]         normal_x,
  output logic signed [14:0]         normal_y,
  output logic signed [15:0]         normal_z,
  output logic                       last_in_frame
);

  hng_cmd_t                    cmd;
  hng_stat_t                   stat;
  logic [$clog2(MAX_LINE)-1:0] addr;

  hng_ctrl #(.MAX_LINE(MAX_LINE)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .action     (action),
    .stat       (stat),
    .cmd        (cmd),
    .addr       (addr)
  );

  hng_dp #(.MAX_LINE(MAX_LINE)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .addr          (addr),
    .high_byte     (high_byte),
    .low_byte      (low_byte),
    .stat          (stat),
    .result_stall  (result_stall),
    .result_valid  (result_valid),
    .column        (column),
    .row           (row),
    .scaled_height (scaled_height),
    .normal_x      (normal_x),
    .normal_y      (normal_y),
    .normal_z      (normal_z),
    .last_in_frame (last_in_frame)
  );

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !stat.out_full)
    else $error("result overwritten while stalled");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> result_valid)
    else $error("loaded result not shown");

  // line store write-back only while no word can be taken
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> item_stall)
    else $error("line store written while accepting");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    stat.norm_done |-> item_stall)
    else $error("normal unit finished while idle");

endmodule

`default_nettype wire

// ===== verif/heightmap_normal_generator_tb.sv =====
// self-checking testbench for heightmap_normal_generator
// depends on hng_pkg and the block's rtl; directed table, then random tiles
`timescale 1ns / 100ps

module heightmap_normal_generator_tb;
  import hng_pkg::*;

  typedef enum logic [1:0] {ROW_CFG, ROW_SAMPLE, ROW_FLUSH} row_kind_t;

  typedef struct {
    row_kind_t    kind;
    logic [1:0]   idx;
    logic [15:0]  val;
    bit           typed;
    logic [15:0]  eh;
    logic [15:0]  ex;
    logic [14:0]  ey;
    logic [15:0]  ez;
  } stim_row_t;

  typedef struct {
    logic [11:0]  col;
    logic [11:0]  rw;
    logic [15:0]  h;
    logic [15:0]  nx;
    logic [14:0]  ny;
    logic [15:0]  nz;
    logic         last;
  } pixel_t;

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0] cfg_data;
  logic item_valid, item_stall, action;
  logic [7:0] high_byte, low_byte;
  logic result_valid, result_stall;
  logic [COORD_W-1:0] column, row;
  logic [15:0] scaled_height;
  logic signed [15:0] normal_x, normal_z;
  logic signed [14:0] normal_y;
  logic last_in_frame;

  heightmap_normal_generator dut (.*);

  // predictor state
  logic [15:0] upper_q[4096];
  logic [15:0] middle_q[4096];
  int unsigned in_col, in_row, fl_col, left_above;
  int unsigned peak_q, width_q, height_q;

  pixel_t pixels_due[$];
  int errors;
  int counted;
  bit calm, start_hold, hold_off;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("heightmap_normal_generator_tb: done, errors");
    $finish;
  end

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // round to nearest of 16384*c/sqrt(s)
  function automatic int q14_part(longint c, logic [127:0] s);
    logic [127:0] a, rhs, lhs, k;
    int lo, hi, m;
    a = c < 0 ? -c : c;
    rhs = (a * a) << 30;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      m = (lo + hi + 1) / 2;
      k = 2 * m - 1;
      lhs = k * k * s;
      if (lhs <= rhs) lo = m;
      else hi = m - 1;
    end
    return c < 0 ? -lo : lo;
  endfunction

  function automatic pixel_t make_pixel(int unsigned col, int unsigned rw, int unsigned ctr,
      int unsigned l, int unsigned r, int unsigned t, int unsigned b, bit last);
    pixel_t px;
    longint p, sh, vx, vy, vz;
    logic [127:0] s;
    int q;
    p = peak_q == 0 ? 1 : peak_q;
    sh = (longint'(ctr) * 65280 + p / 2) / p;
    if (sh > 65280) sh = 65280;
    vx = 255 * (longint'(r) - longint'(l));
    vy = -2 * p;
    vz = 255 * (longint'(b) - longint'(t));
    s = vx * vx + vy * vy + vz * vz;
    px.col = col[11:0];
    px.rw = rw[11:0];
    px.h = sh[15:0];
    q = q14_part(vx, s); px.nx = q[15:0];
    q = q14_part(vy, s); px.ny = q[14:0];
    q = q14_part(vz, s); px.nz = q[15:0];
    px.last = last;
    return px;
  endfunction

  // returns 1 when the word yields a pixel
  function automatic bit predict_word(bit act, logic [15:0] v, output pixel_t px);
    int unsigned w, h, c, r, m, up, l, rt, fc, t;
    bit last;
    w = width_q < 1 ? 1 : (width_q > 4096 ? 4096 : width_q);
    h = height_q < 1 ? 1 : (height_q > 4096 ? 4096 : height_q);
    if (!act) begin
      if (in_row >= h) return 0;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
        if (in_row >= h) return 0;
      end
      c = in_col;
      r = in_row;
      m = middle_q[c];
      up = upper_q[c];
      l = c == 0 ? 0 : left_above;
      rt = c + 1 < w ? middle_q[c + 1] : 0;
      upper_q[c] = 16'(m);
      middle_q[c] = v;
      left_above = m;
      in_col = c + 1;
      if (in_col >= w) begin
        in_col = 0;
        in_row = r + 1;
      end
      if (r < 1) return 0;
      px = make_pixel(c, r - 1, m, l, rt, r - 1 == 0 ? 0 : up, v, 0);
      return 1;
    end
    if (in_row < h) return 0;
    fc = fl_col >= w ? w - 1 : fl_col;
    l = fc == 0 ? 0 : middle_q[fc - 1];
    rt = fc + 1 < w ? middle_q[fc + 1] : 0;
    t = h >= 2 ? upper_q[fc] : 0;
    last = fc == w - 1;
    px = make_pixel(fc, h - 1, middle_q[fc], l, rt, t, 0, last);
    if (last) begin
      in_row = 0;
      in_col = 0;
      fl_col = 0;
      left_above = 0;
    end else begin
      fl_col = fc + 1;
    end
    return 1;
  endfunction

  task automatic send_word(bit act, logic [15:0] v, bit typed = 0, logic [15:0] eh = 0,
      logic [15:0] ex = 0, logic [14:0] ey = 0, logic [15:0] ez = 0);
    bit ok;
    pixel_t px;
    if (!calm && $urandom_range(99) < 17) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    item_valid <= 1'b1;
    action <= act;
    high_byte <= v[15:8];
    low_byte <= v[7:0];
    forever begin
      @(negedge clk);
      ok = !item_stall;
      @(posedge clk);
      if (ok) break;
    end
    if (predict_word(act, v, px)) begin
      if (typed) begin
        px.h = eh;
        px.nx = ex;
        px.ny = ey;
        px.nz = ez;
      end
      pixels_due.push_back(px);
      counted++;
    end
  endtask

  task automatic settle();
    item_valid <= 1'b0;
    wait (pixels_due.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    bit ok;
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    forever begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
      if (ok) break;
    end
    cfg_valid <= 1'b0;
    case (idx)
      REG_PEAK:   peak_q = val;
      REG_WIDTH:  width_q = val[12:0];
      REG_HEIGHT: height_q = val[12:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // result side
  always @(negedge clk) begin
    pixel_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pixels_due.size() == 0) begin
        report("unexpected pixel at column", column, -1);
      end else begin
        want = pixels_due.pop_front();
        if (column !== want.col) report("column", column, want.col);
        if (row !== want.rw) report("row", row, want.rw);
        if (scaled_height !== want.h) report("scaled_height", scaled_height, want.h);
        if (normal_x !== want.nx) report("normal_x", normal_x, $signed(want.nx));
        if (normal_y !== want.ny) report("normal_y", normal_y, $signed(want.ny));
        if (normal_z !== want.nz) report("normal_z", normal_z, $signed(want.nz));
        if (last_in_frame !== want.last) report("last_in_frame", last_in_frame, want.last);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_off) result_stall <= 1'b1;
    else result_stall <= calm ? 1'b0 : ($urandom_range(99) < 17);
  end

  // long receiver hold-off so the block backs up onto its input
  initial begin
    hold_off = 0;
    wait (start_hold);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (3000) @(posedge clk);
    hold_off <= 1'b0;
  end

  stim_row_t steps[$] = '{
    '{ROW_CFG, REG_PEAK, 16'd1, 0, 0, 0, 0, 0},
    '{ROW_CFG, REG_WIDTH, 16'd3, 0, 0, 0, 0, 0},
    '{ROW_CFG, REG_HEIGHT, 16'd3, 0, 0, 0, 0, 0},
    '{ROW_SAMPLE, 0, 16'd0, 0, 0, 0, 0, 0},
    '{ROW_SAMPLE, 0, 16'd0, 0, 0, 0, 0, 0},
    '{ROW_SAMPLE, 0, 16'd0, 0, 0, 0, 0, 0},
    '{ROW_FLUSH, 0, 16'd0, 0, 0, 0, 0, 0},
    // flat zero row above: straight-down normal (y of -16384)
    '{ROW_SAMPLE, 0, 16'd0, 1, 16'd0, 16'd0, 15'h4000, 16'd0},
    '{ROW_SAMPLE, 0, 16'd0, 1, 16'd0, 16'd0, 15'h4000, 16'd0},
    '{ROW_SAMPLE, 0, 16'd0, 1, 16'd0, 16'd0, 15'h4000, 16'd0},
    // full-scale bottom neighbour tips the normal to +z
    '{ROW_SAMPLE, 0, 16'hFFFF, 1, 16'd0, 16'd0, 15'd0, 16'd16384},
    '{ROW_SAMPLE, 0, 16'd0, 1, 16'd0, 16'd0, 15'h4000, 16'd0},
    '{ROW_SAMPLE, 0, 16'd0, 1, 16'd0, 16'd0, 15'h4000, 16'd0},
    '{ROW_SAMPLE, 0, 16'h1234, 0, 0, 0, 0, 0},
    // saturated height, then a full-scale left neighbour
    '{ROW_FLUSH, 0, 16'd0, 1, 16'd65280, 16'd0, 15'h4000, 16'd0},
    '{ROW_FLUSH, 0, 16'd0, 1, 16'd0, -16'sd16384, 15'd0, 16'd0},
    '{ROW_FLUSH, 0, 16'd0, 1, 16'd0, 16'd0, 15'h4000, 16'd0},
    // zero peak and zero sizes clamp to a one-pixel tile
    '{ROW_CFG, REG_PEAK, 16'd0, 0, 0, 0, 0, 0},
    '{ROW_CFG, REG_WIDTH, 16'd0, 0, 0, 0, 0, 0},
    '{ROW_CFG, REG_HEIGHT, 16'd0, 0, 0, 0, 0, 0},
    '{ROW_SAMPLE, 0, 16'h8001, 0, 0, 0, 0, 0},
    '{ROW_FLUSH, 0, 16'd0, 0, 0, 0, 0, 0},
    // widest and tallest tile, shrunk once the first words are in
    '{ROW_CFG, REG_PEAK, 16'd65535, 0, 0, 0, 0, 0},
    '{ROW_CFG, REG_WIDTH, 16'd8191, 0, 0, 0, 0, 0},
    '{ROW_CFG, REG_HEIGHT, 16'd4096, 0, 0, 0, 0, 0},
    '{ROW_SAMPLE, 0, 16'h00FF, 0, 0, 0, 0, 0},
    '{ROW_SAMPLE, 0, 16'hFF00, 0, 0, 0, 0, 0},
    '{ROW_SAMPLE, 0, 16'h5A5A, 0, 0, 0, 0, 0},
    '{ROW_CFG, REG_WIDTH, 16'd3, 0, 0, 0, 0, 0},
    '{ROW_SAMPLE, 0, 16'hA5A5, 0, 0, 0, 0, 0},
    '{ROW_SAMPLE, 0, 16'h0001, 0, 0, 0, 0, 0},
    '{ROW_SAMPLE, 0, 16'hFFFE, 0, 0, 0, 0, 0},
    '{ROW_CFG, REG_HEIGHT, 16'd3, 0, 0, 0, 0, 0},
    '{ROW_SAMPLE, 0, 16'h8000, 0, 0, 0, 0, 0},
    '{ROW_SAMPLE, 0, 16'h7FFF, 0, 0, 0, 0, 0},
    '{ROW_SAMPLE, 0, 16'h0000, 0, 0, 0, 0, 0},
    '{ROW_FLUSH, 0, 16'd0, 0, 0, 0, 0, 0},
    '{ROW_FLUSH, 0, 16'd0, 0, 0, 0, 0, 0},
    '{ROW_FLUSH, 0, 16'd0, 0, 0, 0, 0, 0}
  };

  initial begin
    int unsigned w, h, pk, top;
    bit wide_vals;
    errors = 0;
    counted = 0;
    calm = 0;
    start_hold = 0;
    rst = 1;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    item_valid = 0;
    action = 0;
    high_byte = '0;
    low_byte = '0;
    result_stall = 0;
    for (int i = 0; i < 4096; i++) begin
      upper_q[i] = '0;
      middle_q[i] = '0;
    end
    in_col = 0; in_row = 0; fl_col = 0; left_above = 0;
    peak_q = PEAK_RESET; width_q = SIZE_RESET; height_q = SIZE_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (steps[i]) begin
      case (steps[i].kind)
        ROW_CFG:    write_reg(steps[i].idx, steps[i].val);
        ROW_SAMPLE: send_word(1'b0, steps[i].val, steps[i].typed, steps[i].eh,
                              steps[i].ex, steps[i].ey, steps[i].ez);
        default:    send_word(1'b1, steps[i].val, steps[i].typed, steps[i].eh,
                              steps[i].ex, steps[i].ey, steps[i].ez);
      endcase
    end

    counted = 0;
    while (counted < 600) begin
      calm = counted >= 250 && counted < 370;
      if ($urandom_range(3) != 0) begin
        w = $urandom_range(99) < 10 ? $urandom_range(9, 24) : $urandom_range(3, 8);
        h = $urandom_range(3, 6);
        case ($urandom_range(3))
          0: pk = 65535;
          1: pk = 1;
          2: pk = $urandom_range(1, 65535);
          default: pk = $urandom_range(1, 1000);
        endcase
        write_reg(REG_PEAK, 16'(pk));
        write_reg(REG_WIDTH, 16'(w));
        write_reg(REG_HEIGHT, 16'(h));
      end
      // hold-off starts at the top of a tile so words keep coming behind it
      if (counted >= 100 && !start_hold) start_hold = 1;
      wide_vals = $urandom_range(1);
      top = peak_q * 2 > 65535 ? 65535 : peak_q * 2;
      for (int n = 0; n < width_q * height_q; n++) begin
        // a flush before the tile is complete is ignored
        if ($urandom_range(99) < 5) send_word(1'b1, 16'($urandom));
        send_word(1'b0, wide_vals ? 16'($urandom) : 16'($urandom_range(0, top)));
      end
      if ($urandom_range(1)) send_word(1'b0, 16'($urandom));
      for (int n = 0; n < width_q; n++) send_word(1'b1, 16'($urandom));
    end
    calm = 0;

    item_valid <= 1'b0;
    wait (pixels_due.size() == 0);
    repeat (400) @(posedge clk);
    if (errors == 0) $display("heightmap_normal_generator_tb: done, clean");
    else $display("heightmap_normal_generator_tb: done, errors");
    $finish;
  end

endmodule
